/* rtl/core/set_assoc_lru_cache_sim_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache model block
// Shorthand for clocked implications on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

// Same-cycle implication
`define SACS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SACS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sacs_pkg.sv */
// ----------------------------------------------------------------------------
// sacs_pkg
// Shared constants, codes and types of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package sacs_pkg;

  // Default geometry
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_WAYS         = 8;

  // Field widths
  localparam int ADDR_W     = 64;
  localparam int KIND_W     = 2;
  localparam int OUTCOME_W  = 2;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int OFFSET_W   = 6;
  localparam int SETBITS_W  = 3;
  localparam int WAYSREG_W  = 4;

  // Access kinds
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IFETCH = 2'd3;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_HIT     = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL    = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT   = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_IGNORED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

  // Tag scan status toward the controller
  typedef struct packed {
    logic done;
    logic hit;
  } scan_status_t;

endpackage

`default_nettype wire

/* rtl/core/sacs_access_if.sv */
// ----------------------------------------------------------------------------
// sacs_access_if
// Valid/ready channel carrying one trace access item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacs_access_if import sacs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink   (input valid, input kind, input address, output ready);
endinterface

`default_nettype wire

/* rtl/core/sacs_result_if.sv */
// ----------------------------------------------------------------------------
// sacs_result_if
// Valid/ready channel carrying one result item: outcome and running counts.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacs_result_if import sacs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [COUNT_W-1:0]   hit_count;
  logic [COUNT_W-1:0]   miss_count;
  logic [COUNT_W-1:0]   eviction_count;

  modport source (output valid, output outcome, output hit_count, output miss_count,
                  output eviction_count, input ready);
  modport sink   (input valid, input outcome, input hit_count, input miss_count,
                  input eviction_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/sacs_scan.sv */
// ----------------------------------------------------------------------------
// sacs_scan
// Tag store and serial lookup: one way read per cycle, one shared comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module sacs_scan import sacs_pkg::*; #(
  parameter  int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter  int WAYS         = DEF_WAYS,
  localparam int NUM_SETS     = 1 << MAX_SET_BITS,
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int WC_W         = $clog2(WAYS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SET_W-1:0]  set_idx,
  input  logic [ADDR_W-1:0] tag,
  input  logic [WC_W-1:0]   ways,
  input  logic [WAYS-1:0]   valid_vec,
  input  logic              wr_en,
  input  logic [WAY_W-1:0]  wr_way,
  output scan_status_t      status,
  output logic [WAY_W-1:0]  hit_way
);

  logic [ADDR_W-1:0] tag_mem [NUM_SETS][WAYS];
  logic [ADDR_W-1:0] rd_tag;
  logic              active;
  logic              issuing;
  logic [WC_W-1:0]   issue_way;
  logic              cmp_pending;
  logic [WAY_W-1:0]  cmp_way;
  logic              hit_now;
  logic              last_now;

  // Read stage: one way per cycle while ways remain
  assign issuing = active && (issue_way < ways);

  // Compare stage: shared tag comparator on the registered read
  assign hit_now  = cmp_pending && valid_vec[cmp_way] && (rd_tag == tag);
  assign last_now = cmp_pending && (WC_W'(cmp_way) == ways - WC_W'(1));

  assign status.done = hit_now || last_now;
  assign status.hit  = hit_now;
  assign hit_way     = cmp_way;

  // Tag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[set_idx][wr_way] <= tag;
    end
    rd_tag <= tag_mem[set_idx][issue_way[WAY_W-1:0]];
  end

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      cmp_pending <= 1'b0;
      issue_way   <= '0;
      cmp_way     <= '0;
    end else if (start) begin
      active      <= 1'b1;
      cmp_pending <= 1'b0;
      issue_way   <= '0;
    end else if (status.done) begin
      active      <= 1'b0;
      cmp_pending <= 1'b0;
    end else begin
      cmp_pending <= issuing;
      if (issuing) begin
        issue_way <= issue_way + 1'b1;
        cmp_way   <= issue_way[WAY_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/set_assoc_lru_cache_sim.sv */
// Path: a load, store or modify goes through ST_SCAN, ST_UPDATE and ST_DONE before
//   result.valid rises; the scan stops at a hit, else reads every way in use after
//   clamping. A fetch goes from ST_IDLE to ST_DONE. A full output register held by
//   result.ready adds its wait. The block takes no new item until the result loads.
//   The tag store yields one way per cycle to one shared comparator.
// Reset (rst, synchronous): clears counters, config, sequencer and per-set valid flags.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache model with LRU replacement and hit/miss/evict counts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_lru_cache_sim_macros.svh"

module set_assoc_lru_cache_sim import sacs_pkg::*; #(
  parameter  int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter  int WAYS         = DEF_WAYS,
  localparam int NUM_SETS     = 1 << MAX_SET_BITS,
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int RANK_W       = WAY_W,
  localparam int WC_W         = $clog2(WAYS + 1),
  localparam int SB_W         = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  sacs_access_if.sink           access,
  sacs_result_if.source         result
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration
  logic [OFFSET_W-1:0]  offset_bits;
  logic [SETBITS_W-1:0] set_index_bits;
  logic [WAYSREG_W-1:0] ways_in_use;
  logic [SB_W-1:0]      sbits;
  logic [WC_W-1:0]      ways;

  // Item being worked on
  logic                 accept;
  logic [KIND_W-1:0]    kind_q;
  logic [ADDR_W-1:0]    a_q;
  logic [SET_W-1:0]     set_idx;
  logic [ADDR_W-1:0]    tag_cur;
  logic                 hit_q;
  logic [WAY_W-1:0]     hit_way_q;
  logic [OUTCOME_W-1:0] outcome_q;

  // Scan unit
  scan_status_t         scan_st;
  logic [WAY_W-1:0]     scan_hit_way;
  logic                 tag_we;

  // Per-set metadata: valid bits and ranks
  logic [WAYS-1:0]              meta_valid_mem [NUM_SETS];
  logic [WAYS-1:0][RANK_W-1:0]  meta_rank_mem  [NUM_SETS];
  logic [NUM_SETS-1:0]          row_valid;
  logic [WAYS-1:0]              meta_valid_rd;
  logic [WAYS-1:0][RANK_W-1:0]  meta_rank_rd;
  logic                         row_ok_rd;
  logic                         meta_we;

  // Replacement decision
  logic [WAYS-1:0]              use_mask;
  logic [WAYS-1:0]              valid_base;
  logic [WAYS-1:0]              valid_eff;
  logic [WAYS-1:0][RANK_W-1:0]  rank_base;
  logic                         free_found;
  logic [WAY_W-1:0]             free_way;
  logic [WAY_W-1:0]             victim;
  logic [RANK_W-1:0]            best_rank;
  logic [WAY_W-1:0]             touched;
  logic                         age_all;
  logic [RANK_W-1:0]            old_rank;
  logic [OUTCOME_W-1:0]         outcome_upd;
  logic                         evict;
  logic [WAYS-1:0]              valid_new;
  logic [WAYS-1:0][RANK_W-1:0]  rank_new;
  logic [1:0]                   hit_inc;

  // Counters and output register
  logic [COUNT_W-1:0]   hits_total;
  logic [COUNT_W-1:0]   misses_total;
  logic [COUNT_W-1:0]   evictions_total;
  logic                 out_valid;
  logic                 out_load;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [COUNT_W-1:0]   out_hits;
  logic [COUNT_W-1:0]   out_misses;
  logic [COUNT_W-1:0]   out_evictions;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] v,
                                                 input logic [1:0] inc);
    logic [COUNT_W:0] s;
    s = {1'b0, v} + {{(COUNT_W - 1){1'b0}}, inc};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits    <= '0;
      set_index_bits <= '0;
      ways_in_use    <= WAYSREG_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_OFFSET_BITS:    offset_bits    <= wr_data[OFFSET_W-1:0];
        CFG_SET_INDEX_BITS: set_index_bits <= wr_data[SETBITS_W-1:0];
        CFG_WAYS_IN_USE:    ways_in_use    <= wr_data[WAYSREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp set bits and way count to the built geometry
  always_comb begin
    if (int'(set_index_bits) > MAX_SET_BITS) sbits = SB_W'(MAX_SET_BITS);
    else                                     sbits = SB_W'(set_index_bits);
    if (ways_in_use == '0)               ways = WC_W'(1);
    else if (int'(ways_in_use) > WAYS)   ways = WC_W'(WAYS);
    else                                 ways = WC_W'(ways_in_use);
  end

  // Address split
  assign set_idx = a_q[SET_W-1:0] & ~({SET_W{1'b1}} << sbits);
  assign tag_cur = a_q >> sbits;

  assign access.ready = (state == ST_IDLE);
  assign accept       = access.valid && access.ready;

  // Metadata memory, read every cycle at the current set
  assign meta_we = (state == ST_UPDATE);

  always_ff @(posedge clk) begin
    meta_valid_rd <= meta_valid_mem[set_idx];
    meta_rank_rd  <= meta_rank_mem[set_idx];
    row_ok_rd     <= row_valid[set_idx];
    if (meta_we) begin
      meta_valid_mem[set_idx] <= valid_new;
      meta_rank_mem[set_idx]  <= rank_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (meta_we) begin
      row_valid[set_idx] <= 1'b1;
    end
  end

  // Ways in use; a never-written set reads as all invalid, rank zero
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      use_mask[i] = (WC_W'(i) < ways);
    end
    valid_base = row_ok_rd ? meta_valid_rd : '0;
    rank_base  = row_ok_rd ? meta_rank_rd : '0;
    valid_eff  = valid_base & use_mask;
  end

  // First invalid way, and oldest way (lowest number on a tie)
  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (use_mask[i] && !valid_eff[i]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(i);
      end
    end
    victim    = '0;
    best_rank = rank_base[0];
    for (int i = 1; i < WAYS; i++) begin
      if (use_mask[i] && (rank_base[i] > best_rank)) begin
        victim    = WAY_W'(i);
        best_rank = rank_base[i];
      end
    end
  end

  // Touched way, outcome and new ranks
  always_comb begin
    old_rank = '0;
    if (hit_q) begin
      touched     = hit_way_q;
      age_all     = 1'b0;
      old_rank    = rank_base[hit_way_q];
      outcome_upd = OUT_HIT;
    end else if (free_found) begin
      touched     = free_way;
      age_all     = 1'b1;
      outcome_upd = OUT_FILL;
    end else begin
      touched     = victim;
      age_all     = 1'b1;
      outcome_upd = OUT_EVICT;
    end
    evict = !hit_q && !free_found;

    for (int i = 0; i < WAYS; i++) begin
      rank_new[i] = rank_base[i];
      if (WAY_W'(i) == touched) begin
        rank_new[i] = '0;
      end else if (use_mask[i] && valid_eff[i] &&
                   (age_all || (rank_base[i] < old_rank)) &&
                   (rank_base[i] != RANK_W'(WAYS - 1))) begin
        rank_new[i] = rank_base[i] + 1'b1;
      end
    end
    valid_new          = valid_base;
    valid_new[touched] = 1'b1;
    hit_inc = {1'b0, hit_q} + {1'b0, kind_q == KIND_MODIFY};
  end

  assign tag_we = (state == ST_UPDATE) && !hit_q;

  sacs_scan #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && (access.kind != KIND_IFETCH)),
    .set_idx   (set_idx),
    .tag       (tag_cur),
    .ways      (ways),
    .valid_vec (valid_eff),
    .wr_en     (tag_we),
    .wr_way    (touched),
    .status    (scan_st),
    .hit_way   (scan_hit_way)
  );

  // Sequencer
  assign out_load = (state == ST_DONE) && (!out_valid || result.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = (access.kind == KIND_IFETCH) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_st.done) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= access.kind;
      a_q       <= access.address >> offset_bits;
      outcome_q <= OUT_IGNORED;
    end
    if ((state == ST_SCAN) && scan_st.done) begin
      hit_q     <= scan_st.hit;
      hit_way_q <= scan_hit_way;
    end
    if (state == ST_UPDATE) begin
      outcome_q <= outcome_upd;
    end
  end

  // Running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
    end else if (state == ST_UPDATE) begin
      hits_total      <= sat_add(hits_total, hit_inc);
      misses_total    <= sat_add(misses_total, {1'b0, !hit_q});
      evictions_total <= sat_add(evictions_total, {1'b0, evict});
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_outcome   <= outcome_q;
      out_hits      <= hits_total;
      out_misses    <= misses_total;
      out_evictions <= evictions_total;
    end
  end

  assign result.valid          = out_valid;
  assign result.outcome        = out_outcome;
  assign result.hit_count      = out_hits;
  assign result.miss_count     = out_misses;
  assign result.eviction_count = out_evictions;

  // Checks
  `SACS_ASSERT_NOW(a_done_in_scan, scan_st.done, state == ST_SCAN, "scan done outside scan")
  `SACS_ASSERT_NEXT(a_update_done, state == ST_UPDATE, state == ST_DONE, "update not followed by done")
  `SACS_ASSERT_NOW(a_hits_grow, !$past(rst), hits_total >= $past(hits_total), "hit count fell")
  `SACS_ASSERT_NEXT(a_fetch_skip, accept && access.kind == KIND_IFETCH, state == ST_DONE && outcome_q == OUT_IGNORED, "fetch not ignored")

endmodule

`default_nettype wire

/* verif/tb_set_assoc_lru_cache_sim.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim
// Drives trace accesses into the LRU cache model block and checks each result
// item (outcome and running hit, miss and eviction counts) against a predictor
// with its own tags, valid bits, ranks and counters, or a typed row's values.
// A directed table runs first; randomized phases with varied geometry follow.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_sim import sacs_pkg::*; ();

  localparam int NSETS       = 1 << DEF_MAX_SET_BITS;
  localparam int NWAYS       = DEF_WAYS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 75;

  // Load and store codes are not in the package
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [COUNT_W-1:0]   hits;
    logic [COUNT_W-1:0]   misses;
    logic [COUNT_W-1:0]   evictions;
  } access_result_t;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_op_t;

  typedef struct packed {
    row_op_t              op;
    logic [KIND_W-1:0]    kind;
    logic [ADDR_W-1:0]    addr;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                 typed;
    access_result_t       exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  sacs_access_if access_ch ();
  sacs_result_if result_ch ();

  set_assoc_lru_cache_sim dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .access   (access_ch),
    .result   (result_ch)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [ADDR_W-1:0] tag_mem   [NSETS][NWAYS];
  bit                valid_mem [NSETS][NWAYS];
  logic [2:0]        rank_mem  [NSETS][NWAYS];
  logic [COUNT_W-1:0] hit_tally, miss_tally, evict_tally;
  logic [OFFSET_W-1:0]  cfg_offset;
  logic [SETBITS_W-1:0] cfg_set_bits;
  logic [WAYSREG_W-1:0] cfg_ways;

  access_result_t expected_results[$];
  int errors       = 0;
  int results_seen = 0;
  bit steady       = 1'b0;   // no idling on either side while set

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int eff_set_bits();
    return (cfg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cfg_set_bits);
  endfunction

  function automatic int eff_ways();
    if (cfg_ways == 0) return 1;
    return (cfg_ways > NWAYS) ? NWAYS : int'(cfg_ways);
  endfunction

  // Touched way becomes most recent; younger valid ways age by one
  function automatic void age_ranks(int s, int nw, int w, int old_rank);
    for (int i = 0; i < nw; i++) begin
      if (i != w && valid_mem[s][i] && int'(rank_mem[s][i]) < old_rank &&
          rank_mem[s][i] < 3'(NWAYS - 1))
        rank_mem[s][i] = rank_mem[s][i] + 1'b1;
    end
    rank_mem[s][w] = '0;
  endfunction

  // Look up one access, update the predicted cache state, return the result item
  function automatic access_result_t lookup_and_update(logic [KIND_W-1:0] kind,
                                                       logic [ADDR_W-1:0] addr);
    access_result_t r;
    int sb, nw, s, hit_way, free_way, victim;
    logic [ADDR_W-1:0] a, tag;
    r.outcome = OUT_IGNORED;
    if (kind != KIND_IFETCH) begin
      sb = eff_set_bits();
      nw = eff_ways();
      a = addr >> cfg_offset;
      s = int'(a & ((64'd1 << sb) - 64'd1));
      tag = a >> sb;
      hit_way = -1;
      free_way = -1;
      for (int i = 0; i < nw; i++) begin
        if (valid_mem[s][i]) begin
          if (hit_way < 0 && tag_mem[s][i] == tag) hit_way = i;
        end else if (free_way < 0) begin
          free_way = i;
        end
      end
      if (hit_way >= 0) begin
        age_ranks(s, nw, hit_way, int'(rank_mem[s][hit_way]));
        hit_tally = sat_inc(hit_tally);
        r.outcome = OUT_HIT;
      end else if (free_way >= 0) begin
        tag_mem[s][free_way] = tag;
        valid_mem[s][free_way] = 1'b1;
        age_ranks(s, nw, free_way, NWAYS);
        miss_tally = sat_inc(miss_tally);
        r.outcome = OUT_FILL;
      end else begin
        // oldest rank wins, lowest way on a tie
        victim = 0;
        for (int i = 1; i < nw; i++)
          if (rank_mem[s][i] > rank_mem[s][victim]) victim = i;
        tag_mem[s][victim] = tag;
        age_ranks(s, nw, victim, NWAYS);
        miss_tally = sat_inc(miss_tally);
        evict_tally = sat_inc(evict_tally);
        r.outcome = OUT_EVICT;
      end
      // second half of a modify always hits
      if (kind == KIND_MODIFY) hit_tally = sat_inc(hit_tally);
    end
    r.hits = hit_tally;
    r.misses = miss_tally;
    r.evictions = evict_tally;
    return r;
  endfunction

  // Random access kind other than a fetch
  function automatic logic [KIND_W-1:0] pick_kind(int sel);
    case (sel)
      0:       return KIND_LOAD;
      1:       return KIND_STORE;
      default: return KIND_MODIFY;
    endcase
  endfunction

  // Directed table rows
  function automatic stim_row_t acc(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr);
    return '{ROW_ACCESS, kind, addr, CFG_OFFSET_BITS, '0, 1'b0, '0};
  endfunction

  function automatic stim_row_t acc_exp(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                        logic [OUTCOME_W-1:0] oc, int h, int m, int e);
    return '{ROW_ACCESS, kind, addr, CFG_OFFSET_BITS, '0, 1'b1,
             '{oc, COUNT_W'(h), COUNT_W'(m), COUNT_W'(e)}};
  endfunction

  function automatic stim_row_t wr(logic [CFG_IDX_W-1:0] idx, int val);
    return '{ROW_WRITE, KIND_LOAD, '0, idx, CFG_DATA_W'(val), 1'b0, '0};
  endfunction

  // Drop valid and wait until every outstanding result item has come back
  task automatic settle();
    access_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    settle();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      CFG_OFFSET_BITS:    cfg_offset   = OFFSET_W'(val);
      CFG_SET_INDEX_BITS: cfg_set_bits = SETBITS_W'(val);
      CFG_WAYS_IN_USE:    cfg_ways     = WAYSREG_W'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one access item; predict its result once accepted
  task automatic send_access(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                             bit typed, access_result_t exp);
    int gap;
    access_result_t pred;
    gap = 0;
    while (!steady && $urandom_range(99) < 27) gap++;
    if (gap > 0) begin
      access_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    access_ch.valid   <= 1'b1;
    access_ch.kind    <= kind;
    access_ch.address <= addr;
    do @(posedge clk); while (!access_ch.ready);
    pred = lookup_and_update(kind, addr);
    expected_results.push_back(typed ? exp : pred);
  endtask

  // Result side: check accepted items, random back-pressure, one long hold
  initial begin
    int hold_left;
    bit hold_done;
    access_result_t exp;
    hold_left = 0;
    hold_done = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item outcome %0d", $time, result_ch.outcome);
          errors++;
        end else begin
          exp = expected_results.pop_front();
          if (result_ch.outcome !== exp.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time, exp.outcome,
                     result_ch.outcome);
            errors++;
          end
          if (result_ch.hit_count !== exp.hits) begin
            $display("%0t: hit_count expected %0d actual %0d", $time, exp.hits,
                     result_ch.hit_count);
            errors++;
          end
          if (result_ch.miss_count !== exp.misses) begin
            $display("%0t: miss_count expected %0d actual %0d", $time, exp.misses,
                     result_ch.miss_count);
            errors++;
          end
          if (result_ch.eviction_count !== exp.evictions) begin
            $display("%0t: eviction_count expected %0d actual %0d", $time, exp.evictions,
                     result_ch.eviction_count);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 200) begin
        // long stall so the block backs up and stops taking items
        hold_done = 1'b1;
        hold_left = 80;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= steady || ($urandom_range(99) >= 27);
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    stim_row_t plan[$];
    int items, sb, nw, off, pick;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr, tag_base, tagv, setv, lowv;

    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    access_ch.valid = 1'b0;
    access_ch.kind = '0;
    access_ch.address = '0;

    // Predictor reset
    for (int s = 0; s < NSETS; s++)
      for (int w = 0; w < NWAYS; w++) begin
        tag_mem[s][w] = '0;
        valid_mem[s][w] = 1'b0;
        rank_mem[s][w] = '0;
      end
    hit_tally = '0;
    miss_tally = '0;
    evict_tally = '0;
    cfg_offset = '0;
    cfg_set_bits = '0;
    cfg_ways = 4'd1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: one set, one way
    plan.push_back(acc_exp(KIND_IFETCH, '1, OUT_IGNORED, 0, 0, 0));
    plan.push_back(acc_exp(KIND_LOAD, '0, OUT_FILL, 0, 1, 0));
    plan.push_back(acc_exp(KIND_LOAD, '0, OUT_HIT, 1, 1, 0));
    plan.push_back(acc_exp(KIND_STORE, '1, OUT_EVICT, 1, 2, 1));
    plan.push_back(acc_exp(KIND_MODIFY, '1, OUT_HIT, 3, 2, 1));
    plan.push_back(acc_exp(KIND_MODIFY, '0, OUT_EVICT, 4, 3, 2));
    plan.push_back(acc_exp(KIND_IFETCH, '0, OUT_IGNORED, 4, 3, 2));
    // Widest offset, set bits above the maximum, zero ways
    plan.push_back(wr(CFG_OFFSET_BITS, 63));
    plan.push_back(wr(CFG_SET_INDEX_BITS, 7));
    plan.push_back(wr(CFG_WAYS_IN_USE, 0));
    plan.push_back(acc(KIND_LOAD, 64'h8000_0000_0000_0000));
    plan.push_back(acc(KIND_LOAD, 64'h0));
    plan.push_back(acc(KIND_STORE, 64'h7FFF_FFFF_FFFF_FFFF));
    // Ways above the maximum: fill one set, then evict the least recently used way
    plan.push_back(wr(CFG_OFFSET_BITS, 0));
    plan.push_back(wr(CFG_SET_INDEX_BITS, 0));
    plan.push_back(wr(CFG_WAYS_IN_USE, 15));
    plan.push_back(acc(KIND_LOAD, 64'hAAAA_AAAA_AAAA_AAAA));
    plan.push_back(acc(KIND_STORE, 64'h5555_5555_5555_5555));
    plan.push_back(acc(KIND_LOAD, 64'd1));
    plan.push_back(acc(KIND_MODIFY, 64'd2));
    plan.push_back(acc(KIND_LOAD, 64'd3));
    plan.push_back(acc(KIND_STORE, 64'd4));
    plan.push_back(acc(KIND_LOAD, 64'd5));
    plan.push_back(acc(KIND_LOAD, 64'd6));
    plan.push_back(acc(KIND_LOAD, 64'hAAAA_AAAA_AAAA_AAAA));
    plan.push_back(acc(KIND_LOAD, 64'd0));
    // Full set index range
    plan.push_back(wr(CFG_WAYS_IN_USE, NWAYS));
    plan.push_back(wr(CFG_OFFSET_BITS, 3));
    plan.push_back(wr(CFG_SET_INDEX_BITS, DEF_MAX_SET_BITS));
    plan.push_back(acc(KIND_LOAD, 64'h0000_0000_0000_01F8));
    plan.push_back(acc(KIND_IFETCH, 64'h0000_0000_0000_01F8));

    foreach (plan[i]) begin
      if (plan[i].op == ROW_WRITE) write_reg(plan[i].reg_idx, int'(plan[i].reg_val));
      else send_access(plan[i].kind, plan[i].addr, plan[i].typed, plan[i].exp);
    end

    // Random phases, each with its own geometry
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        write_reg(CFG_OFFSET_BITS, 0);
        write_reg(CFG_SET_INDEX_BITS, 0);
        write_reg(CFG_WAYS_IN_USE, 1);
      end else if (ph == 1) begin
        write_reg(CFG_OFFSET_BITS, 63);
        write_reg(CFG_SET_INDEX_BITS, 7);
        write_reg(CFG_WAYS_IN_USE, 15);
      end else begin
        write_reg(CFG_OFFSET_BITS, ($urandom_range(1) == 0) ? $urandom_range(8)
                                                            : $urandom_range(63));
        write_reg(CFG_SET_INDEX_BITS, $urandom_range(7));
        write_reg(CFG_WAYS_IN_USE, $urandom_range(15));
      end
      steady = (ph == 3);
      sb = eff_set_bits();
      nw = eff_ways();
      off = int'(cfg_offset);
      tag_base = {$urandom, $urandom};
      items = 0;
      while (items < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        kind = (pick < 8) ? KIND_IFETCH : pick_kind($urandom_range(2));
        if ($urandom_range(99) < 20) begin
          addr = {$urandom, $urandom};
        end else begin
          // few tags over few sets so lines are reused and evicted
          tagv = tag_base + 64'($urandom_range(nw + 2));
          setv = ($urandom_range(9) == 0) ? 64'($urandom) : 64'($urandom_range(3));
          setv = setv & ((64'd1 << sb) - 64'd1);
          lowv = {$urandom, $urandom} & ((64'd1 << off) - 64'd1);
          addr = (tagv << (sb + off)) | (setv << off) | lowv;
        end
        send_access(kind, addr, 1'b0, '0);
        if (kind != KIND_IFETCH) items++;
      end
    end
    steady = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
